@@ rtl/sequential_list_engine_macros.svh @@
// assertion macros shared by the list engine
`ifndef SEQUENTIAL_LIST_ENGINE_MACROS_SVH
`define SEQUENTIAL_LIST_ENGINE_MACROS_SVH

// condition must hold in the same cycle
`define LSE_ASSERT_NOW(label, clk, rst, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error(msg);

// condition implies expression in the next cycle
`define LSE_ASSERT_NEXT(label, clk, rst, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error(msg);

`endif

@@ rtl/lse_pkg.sv @@
`default_nettype none

package lse_pkg;

  // list geometry
  localparam int DEPTH = 16;
  localparam int WIDTH = 32;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int IDX_W = $clog2(DEPTH);

  // fixed field widths
  localparam int OP_W    = 3;
  localparam int VALUE_W = 32;
  localparam int POS_W   = 4;
  localparam int STAT_W  = 2;
  localparam int CMP_W   = (CNT_W > POS_W) ? CNT_W : POS_W;

  // operation codes
  typedef enum logic [OP_W-1:0] {
    OP_PUSH_BACK,
    OP_PUSH_FRONT,
    OP_POP_BACK,
    OP_POP_FRONT,
    OP_DELETE
  } op_t;

  // result status codes
  typedef enum logic [STAT_W-1:0] {
    STAT_OK,
    STAT_FULL,
    STAT_EMPTY,
    STAT_BADPOS
  } stat_t;

  // datapath actions
  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_PUSH_BACK,
    ACT_PUSH_FRONT,
    ACT_POP_BACK,
    ACT_POP_FRONT,
    ACT_DELETE
  } act_t;

  // controller states
  typedef enum logic {
    S_IDLE,
    S_HOLD
  } fsm_t;

  // controller to datapath
  typedef struct packed {
    logic  load;
    act_t  act;
    stat_t stat;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic full;
    logic empty;
    logic pos_ok;
  } dp_stat_t;

endpackage

`default_nettype wire

@@ rtl/lse_datapath.sv @@
`default_nettype none

module lse_datapath import lse_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire cmd_t               cmd,
  input  wire logic [VALUE_W-1:0] value,
  input  wire logic [POS_W-1:0]   position,
  output dp_stat_t                dp_stat,
  output logic [STAT_W-1:0]       status,
  output logic [CNT_W-1:0]        count
);

  logic [WIDTH-1:0] entries      [DEPTH];
  logic [WIDTH-1:0] entries_next [DEPTH];
  logic [CNT_W-1:0] fill;
  logic [CNT_W-1:0] fill_next;
  stat_t            stat;
  logic [WIDTH-1:0] word;
  logic [CMP_W-1:0] pos_ext;
  logic [CMP_W-1:0] fill_ext;
  logic [IDX_W-1:0] tail_idx;
  logic [IDX_W-1:0] rm_idx;

  // operand shaping
  assign word     = WIDTH'(value);
  assign pos_ext  = CMP_W'(position);
  assign fill_ext = CMP_W'(fill);
  assign tail_idx = IDX_W'(fill);
  assign rm_idx   = (cmd.act == ACT_POP_FRONT) ? '0 : IDX_W'(pos_ext);

  // flags for the controller
  assign dp_stat.full   = (fill == CNT_W'(DEPTH));
  assign dp_stat.empty  = (fill == '0);
  assign dp_stat.pos_ok = (pos_ext < fill_ext);

  // next list contents and fill level
  always_comb begin
    entries_next = entries;
    fill_next    = fill;
    if (cmd.load) begin
      case (cmd.act)
        ACT_PUSH_BACK: begin
          entries_next[tail_idx] = word;
          fill_next = fill + CNT_W'(1);
        end
        ACT_PUSH_FRONT: begin
          entries_next[0] = word;
          for (int i = 1; i < DEPTH; i++) begin
            entries_next[i] = entries[i-1];
          end
          fill_next = fill + CNT_W'(1);
        end
        ACT_POP_BACK: begin
          fill_next = fill - CNT_W'(1);
        end
        ACT_POP_FRONT, ACT_DELETE: begin
          for (int i = 0; i < DEPTH - 1; i++) begin
            if (IDX_W'(i) >= rm_idx) begin
              entries_next[i] = entries[i+1];
            end
          end
          fill_next = fill - CNT_W'(1);
        end
        default: begin
          fill_next = fill;
        end
      endcase
    end
  end

  // fill level and result status
  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else begin
      fill <= fill_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      stat <= cmd.stat;
    end
  end

  // storage chain
  always_ff @(posedge clk) begin
    entries <= entries_next;
  end

  assign status = stat;
  assign count  = fill;

endmodule

`default_nettype wire

@@ rtl/lse_ctrl.sv @@
`default_nettype none

module lse_ctrl import lse_pkg::*; (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            req_valid,
  output logic                 req_stall,
  input  wire logic [OP_W-1:0] op,
  output logic                 rsp_valid,
  input  wire logic            rsp_stall,
  input  wire dp_stat_t        dp_stat,
  output cmd_t                 cmd
);

  fsm_t state;
  fsm_t state_next;
  act_t act;
  stat_t stat;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // handshake and next state
  always_comb begin
    state_next = state;
    req_stall  = 1'b0;
    rsp_valid  = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          state_next = S_HOLD;
        end
      end
      S_HOLD: begin
        rsp_valid = 1'b1;
        req_stall = rsp_stall;
        if (!rsp_stall && !req_valid) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // operation decode against the current fill level
  always_comb begin
    act  = ACT_NONE;
    stat = STAT_OK;
    unique case (op_t'(op))
      OP_PUSH_BACK: begin
        if (dp_stat.full) stat = STAT_FULL;
        else act = ACT_PUSH_BACK;
      end
      OP_PUSH_FRONT: begin
        if (dp_stat.full) stat = STAT_FULL;
        else act = ACT_PUSH_FRONT;
      end
      OP_POP_BACK: begin
        if (dp_stat.empty) stat = STAT_EMPTY;
        else act = ACT_POP_BACK;
      end
      OP_POP_FRONT: begin
        if (dp_stat.empty) stat = STAT_EMPTY;
        else act = ACT_POP_FRONT;
      end
      OP_DELETE: begin
        if (dp_stat.empty) stat = STAT_EMPTY;
        else if (!dp_stat.pos_ok) stat = STAT_BADPOS;
        else act = ACT_DELETE;
      end
      default: begin
        act  = ACT_NONE;
        stat = STAT_OK;
      end
    endcase
  end

  // command to the datapath on each input transfer
  assign cmd.load = req_valid && !req_stall;
  assign cmd.act  = act;
  assign cmd.stat = stat;

endmodule

`default_nettype wire

@@ rtl/sequential_list_engine.sv @@
// Ordered list of up to 16 words with push and pop at both ends and delete
// at a position. Each request returns one response with a status and the
// number of words held after it. A request is applied in the cycle it
// transfers and its response appears registered in the next cycle; a new
// request transfers in the same cycle the previous response is taken, so
// the block sustains one item per clock while rsp_stall is low. That figure
// is set by the storage chain, whose registers all shift in parallel. Stored
// words are not readable at the ports and hold no defined value after reset.
`default_nettype none

`include "sequential_list_engine_macros.svh"

module sequential_list_engine import lse_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               req_valid,
  output logic                    req_stall,
  input  wire logic [OP_W-1:0]    op,
  input  wire logic [VALUE_W-1:0] value,
  input  wire logic [POS_W-1:0]   position,
  output logic                    rsp_valid,
  input  wire logic               rsp_stall,
  output logic [STAT_W-1:0]       status,
  output logic [CNT_W-1:0]        count
);

  cmd_t     cmd;
  dp_stat_t dp_stat;

  // control
  lse_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .op        (op),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .dp_stat   (dp_stat),
    .cmd       (cmd)
  );

  // storage and fill level
  lse_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .value    (value),
    .position (position),
    .dp_stat  (dp_stat),
    .status   (status),
    .count    (count)
  );

  // checks
  `LSE_ASSERT_NOW(a_count_bound, clk, rst, 1'b1, count <= CNT_W'(DEPTH), "count above depth")
  `LSE_ASSERT_NEXT(a_count_hold, clk, rst, !cmd.load, $stable(count), "count moved without transfer")
  `LSE_ASSERT_NEXT(a_rsp_after_req, clk, rst, cmd.load, rsp_valid, "no response after request")
  `LSE_ASSERT_NEXT(a_push_grows, clk, rst, cmd.load && (cmd.act == ACT_PUSH_BACK || cmd.act == ACT_PUSH_FRONT), count == $past(count) + CNT_W'(1), "push did not grow list")

endmodule

`default_nettype wire
